### rtl/vtda_pkg.sv
// shared constants, angle table and flag type for the direction angle unit
package vtda_pkg;

  // components are scaled by 2^PRESCALE before the cordic pass
  localparam int PRESCALE = 8;
  // headroom over the sample width for prescale, quadrant swap and cordic gain
  localparam int GUARD_BITS = 10;
  // angle accumulator, signed Q.16 radians
  localparam int ANGLE_W = 20;
  // result width, signed Q3.13 radians
  localparam int OUT_W = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int TABLE_IDX_W = 5;
  // cordic iterations done between two pipeline registers
  localparam int STEPS_PER_STAGE = 8;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [OUT_W-1:0] PI_Q13 = 16'sd25736;

  // round(atan(2^-i) * 2^16), zero past index 16
  localparam logic signed [ANGLE_W-1:0] ANG_TABLE [ANG_TABLE_LEN] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047, 20'sd1024, 20'sd512,
    20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16, 20'sd8, 20'sd4, 20'sd2,
    20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0
  };

  // y was zero: the result is fixed, minus pi when x is zero or positive
  typedef struct packed {
    logic special;
    logic neg_pi;
  } vtda_flags_t;

endpackage

### rtl/vector_to_direction_angle_unit.sv
// top level of the vector to "from" direction angle unit
//
// takes one (x, y) vector word per cycle on the input channel while
// in_ready_o is high and returns atan2(-y, -x) as a signed Q3.13 radian word
// (pi = 25736) on the output channel, both with valid/ready handshakes
// the input register applies negation, 2^8 prescale and a quarter-turn
// pre-rotation for the left half-plane; the cordic iterations follow in
// groups of up to eight, one pipeline register per group; rounding and
// saturation sit in front of the result register
// a word passes the input register, one register per cordic group and the
// result register; throughput is one word per cycle while out_ready_i is
// high; the longest group of eight add/subtract steps is the critical path
// y equal to zero gives minus pi for x zero or positive and 0 for x negative
// reset clears every stage valid bit; the pipeline then reads as empty
// when the receiver stalls, each stage holds its word and in_ready_o drops
// only once every stage is full, so bubbles are squeezed out first
module vector_to_direction_angle_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    x_component_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    y_component_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [vtda_pkg::OUT_W-1:0] direction_angle_o
);
  import vtda_pkg::*;

  // working width for the rotated components
  localparam int WORK_W = SAMPLE_WIDTH + GUARD_BITS;
  // the angle table ends at 24 entries
  localparam int EFF_STEPS = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;
  localparam int NUM_STAGES = (EFF_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // pipeline slot k is the output of the k-th register stage
  logic                      valid_s [NUM_STAGES+1];
  logic                      ready_s [NUM_STAGES+1];
  logic signed [WORK_W-1:0]  a_s     [NUM_STAGES+1];
  logic signed [WORK_W-1:0]  b_s     [NUM_STAGES+1];
  logic signed [ANGLE_W-1:0] z_s     [NUM_STAGES+1];
  vtda_flags_t               flags_s [NUM_STAGES+1];

  // input register and quadrant pre-rotation
  vtda_prerot #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .WORK_W      (WORK_W)
  ) u_prerot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_component_i(x_component_i),
    .y_component_i(y_component_i),
    .out_valid_o  (valid_s[0]),
    .out_ready_i  (ready_s[0]),
    .a_o          (a_s[0]),
    .b_o          (b_s[0]),
    .z_o          (z_s[0]),
    .flags_o      (flags_s[0])
  );

  // cordic vectoring, up to eight iterations per stage
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int FIRST = s * STEPS_PER_STAGE;
    localparam int COUNT = (EFF_STEPS - FIRST < STEPS_PER_STAGE) ?
                           (EFF_STEPS - FIRST) : STEPS_PER_STAGE;

    vtda_stage #(
      .WORK_W    (WORK_W),
      .FIRST_STEP(FIRST),
      .STEP_COUNT(COUNT)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid_s[s]),
      .in_ready_o (ready_s[s]),
      .a_i        (a_s[s]),
      .b_i        (b_s[s]),
      .z_i        (z_s[s]),
      .flags_i    (flags_s[s]),
      .out_valid_o(valid_s[s+1]),
      .out_ready_i(ready_s[s+1]),
      .a_o        (a_s[s+1]),
      .b_o        (b_s[s+1]),
      .z_o        (z_s[s+1]),
      .flags_o    (flags_s[s+1])
    );
  end

  // rounding, saturation and result register; the final components are
  // not needed for the angle
  vtda_round u_round (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (valid_s[NUM_STAGES]),
    .in_ready_o       (ready_s[NUM_STAGES]),
    .z_i              (z_s[NUM_STAGES]),
    .flags_i          (flags_s[NUM_STAGES]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .direction_angle_o(direction_angle_o)
  );

endmodule

### rtl/vtda_prerot.sv
// input register with negation, prescale and quadrant pre-rotation
module vtda_prerot #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int WORK_W = 26
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     x_component_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     y_component_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [WORK_W-1:0]           a_o,
  output logic signed [WORK_W-1:0]           b_o,
  output logic signed [vtda_pkg::ANGLE_W-1:0] z_o,
  output vtda_pkg::vtda_flags_t              flags_o
);
  import vtda_pkg::*;

  logic                      valid_q;
  logic signed [WORK_W-1:0]  a_q, b_q, a_d, b_d;
  logic signed [WORK_W-1:0]  a_neg, b_neg;
  logic signed [ANGLE_W-1:0] z_q, z_d;
  vtda_flags_t               flags_q, flags_d;

  always_comb begin
    a_neg = (-WORK_W'(x_component_i)) <<< PRESCALE;
    b_neg = (-WORK_W'(y_component_i)) <<< PRESCALE;
    flags_d.special = (y_component_i == '0);
    flags_d.neg_pi  = !x_component_i[SAMPLE_WIDTH-1];
    a_d = a_neg;
    b_d = b_neg;
    z_d = '0;
    // left half-plane: turn by a quarter so that a is non-negative
    if (a_neg[WORK_W-1]) begin
      if (!b_neg[WORK_W-1]) begin
        a_d = b_neg;
        b_d = -a_neg;
        z_d = HALF_PI_Q16;
      end else begin
        a_d = -b_neg;
        b_d = a_neg;
        z_d = -HALF_PI_Q16;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q     <= a_d;
      b_q     <= b_d;
      z_q     <= z_d;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = valid_q;
  assign a_o         = a_q;
  assign b_o         = b_q;
  assign z_o         = z_q;
  assign flags_o     = flags_q;

endmodule

### rtl/vtda_stage.sv
// one registered group of cordic vectoring iterations
module vtda_stage #(
  parameter int WORK_W = 26,
  parameter int FIRST_STEP = 0,
  parameter int STEP_COUNT = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [WORK_W-1:0]           a_i,
  input  logic signed [WORK_W-1:0]           b_i,
  input  logic signed [vtda_pkg::ANGLE_W-1:0] z_i,
  input  vtda_pkg::vtda_flags_t              flags_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [WORK_W-1:0]           a_o,
  output logic signed [WORK_W-1:0]           b_o,
  output logic signed [vtda_pkg::ANGLE_W-1:0] z_o,
  output vtda_pkg::vtda_flags_t              flags_o
);
  import vtda_pkg::*;

  logic                      valid_q;
  logic signed [WORK_W-1:0]  a_q, b_q, a_d, b_d, da, db;
  logic signed [ANGLE_W-1:0] z_q, z_d;
  vtda_flags_t               flags_q;

  always_comb begin
    a_d = a_i;
    b_d = b_i;
    z_d = z_i;
    da  = '0;
    db  = '0;
    for (int i = 0; i < STEP_COUNT; i++) begin
      da = b_d >>> (FIRST_STEP + i);
      db = a_d >>> (FIRST_STEP + i);
      // drive b toward zero
      if (!b_d[WORK_W-1]) begin
        a_d = a_d + da;
        b_d = b_d - db;
        z_d = z_d + ANG_TABLE[TABLE_IDX_W'(FIRST_STEP + i)];
      end else begin
        a_d = a_d - da;
        b_d = b_d + db;
        z_d = z_d - ANG_TABLE[TABLE_IDX_W'(FIRST_STEP + i)];
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q     <= a_d;
      b_q     <= b_d;
      z_q     <= z_d;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o = valid_q;
  assign a_o         = a_q;
  assign b_o         = b_q;
  assign z_o         = z_q;
  assign flags_o     = flags_q;

endmodule

### rtl/vtda_round.sv
// rounding to Q3.13, saturation, special cases and the result register
module vtda_round (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vtda_pkg::ANGLE_W-1:0] z_i,
  input  vtda_pkg::vtda_flags_t              flags_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vtda_pkg::OUT_W-1:0]  direction_angle_o
);
  import vtda_pkg::*;

  logic                      valid_q;
  logic signed [ANGLE_W-1:0] rounded, pi_ext;
  logic signed [OUT_W-1:0]   angle_q, angle_d;

  always_comb begin
    pi_ext  = ANGLE_W'(PI_Q13);
    rounded = (z_i + ANGLE_W'(4)) >>> 3;
    if (flags_i.special) begin
      angle_d = flags_i.neg_pi ? -PI_Q13 : '0;
    end else if (rounded > pi_ext) begin
      angle_d = PI_Q13;
    end else if (rounded < -pi_ext) begin
      angle_d = -PI_Q13;
    end else begin
      angle_d = rounded[OUT_W-1:0];
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign direction_angle_o = angle_q;

endmodule

### rtl/vtda_checker.sv
// port-level checks for the direction angle unit, bound to the top level
module vtda_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [vtda_pkg::OUT_W-1:0] direction_angle_o
);
  import vtda_pkg::*;

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(direction_angle_o))
    else $error("result word changed or dropped while stalled");

  // results always lie within minus pi to pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_angle_o <= PI_Q13) && (direction_angle_o >= -PI_Q13))
    else $error("result angle out of range");

  // the input side only backs up when the output is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // no result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind vector_to_direction_angle_unit vtda_checker u_vtda_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .direction_angle_o(direction_angle_o)
);
